// ===== rtl/adfp_pkg.sv =====
`timescale 1ns / 1ps
// Package for the ASCII decimal to fixed-point unit: character codes, limits, power-of-ten table.
package adfp_pkg;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;

	localparam int MANT_W = 64;
	localparam int FCNT_W = 4;
	localparam int POW_W  = 40;
	localparam int INT_W  = 32;

	localparam logic [FCNT_W-1:0] MAX_FRAC_DIGITS = 4'd9;

	localparam logic [MANT_W-1:0] INT_CAP    = 64'h0000_0001_0000_0000;
	localparam logic [MANT_W-1:0] FRAC_GUARD = 64'hFFFF_FFFF_FFFF_FFF6 / 64'd10;

	function automatic logic [POW_W-1:0] pow_ten(input logic [FCNT_W-1:0] n);
		logic [POW_W-1:0] p;
		unique case (n)
			4'd0:    p = 40'd1;
			4'd1:    p = 40'd10;
			4'd2:    p = 40'd100;
			4'd3:    p = 40'd1000;
			4'd4:    p = 40'd10000;
			4'd5:    p = 40'd100000;
			4'd6:    p = 40'd1000000;
			4'd7:    p = 40'd10000000;
			4'd8:    p = 40'd100000000;
			4'd9:    p = 40'd1000000000;
			4'd10:   p = 40'd10000000000;
			4'd11:   p = 40'd100000000000;
			4'd12:   p = 40'd1000000000000;
			default: p = 40'd1;
		endcase
		return p;
	endfunction

endpackage

// ===== rtl/ascii_decimal_to_fixed_point_unit.sv =====
`timescale 1ns / 1ps
// Top level: ASCII decimal string parser with an iterative fixed-point divider.
//
// Input stream s_*: one character per request in s_tdata, s_tuser[0] marks the
// first character of a new number. Leading space/tab/newline are skipped, one
// sign, integer digits, one '.', fraction digits; any other character ends the
// number and yields one result on m_*: value (signed, FRAC_BITS fraction bits)
// and a saturation flag. Characters after the end are dropped until a start.
// Timing: s_tready stays high while characters continue a number. After the
// ending request s_tready is low until the result is loaded; states SETUP,
// CHECK and DONE lie between, and SETUP goes straight to DONE when the integer
// part is out of range. When fraction digits were kept and the integer part
// is in range, the DIV state of a one-bit-per-cycle restoring divider
// (mantissa / 10^digits) comes between SETUP and CHECK. The next request is
// taken once the result is loaded into the output register.
// The result sits in an output register, so new characters are accepted while
// it waits. If the receiver stalls and a second result is ready, the block
// holds it and stops accepting until the output register frees.
// Reset (arst_n low) clears the parser to waiting for a start and empties the
// output register.
module ascii_decimal_to_fixed_point_unit
	import adfp_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [7:0] s_tdata,                 // [7:0] ch
	input  logic [0:0] s_tuser,                 // [0] start_req
	output logic m_tvalid,
	input  logic m_tready,
	output logic [((INT_W+FRAC_BITS+1+7)/8)*8-1:0] m_tdata  // [VW-1:0] value, [VW] saturated
);

	localparam int VAL_W = INT_W + FRAC_BITS;
	localparam int OUT_W = ((VAL_W + 1 + 7) / 8) * 8;
	localparam int CNT_W = $clog2(VAL_W + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LEAD  = 3'd1;
	localparam logic [2:0] ST_INT   = 3'd2;
	localparam logic [2:0] ST_FRAC  = 3'd3;
	localparam logic [2:0] ST_SETUP = 3'd4;
	localparam logic [2:0] ST_DIV   = 3'd5;
	localparam logic [2:0] ST_CHECK = 3'd6;
	localparam logic [2:0] ST_DONE  = 3'd7;

	logic [2:0]         state_q, state_d;
	logic               neg_q, neg_d;
	logic [MANT_W-1:0]  mant_q, mant_d;
	logic [FCNT_W-1:0]  fcnt_q, fcnt_d;
	logic               ovf_q, ovf_d;

	logic [POW_W-1:0]   p_q;
	logic [POW_W:0]     r_q;
	logic [VAL_W-1:0]   sh_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               sat_q;

	logic               m_tvalid_q;
	logic [OUT_W-1:0]   m_tdata_q;

	logic               s_fire;
	logic               start;
	logic [2:0]         eff_state;
	logic               eff_neg;
	logic [MANT_W-1:0]  eff_mant;
	logic [FCNT_W-1:0]  eff_fcnt;
	logic               eff_ovf;
	logic [7:0]         ch;
	logic               is_digit;
	logic               is_ws;
	logic [3:0]         dig;
	logic [MANT_W-1:0]  mul10;

	logic [POW_W-1:0]   pow_sel;
	logic               too_big;
	logic [POW_W:0]     r_shift;
	logic               r_ge;
	logic [VAL_W-1:0]   limit;
	logic               out_free;
	logic [VAL_W-1:0]   value_out;

	assign s_tready  = ~state_q[2];
	assign s_fire    = s_tvalid & s_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign out_free  = ~m_tvalid_q | m_tready;

	assign ch        = s_tdata;
	assign start     = s_tuser[0];
	assign eff_state = start ? ST_LEAD : state_q;
	assign eff_neg   = start ? 1'b0 : neg_q;
	assign eff_mant  = start ? '0 : mant_q;
	assign eff_fcnt  = start ? '0 : fcnt_q;
	assign eff_ovf   = start ? 1'b0 : ovf_q;

	assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign is_ws     = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_LF);
	assign dig       = 4'(ch - CH_ZERO);
	assign mul10     = (eff_mant << 3) + (eff_mant << 1) + MANT_W'(dig);

	assign pow_sel   = pow_ten(fcnt_q);
	assign too_big   = {8'd0, mant_q} >= {pow_sel, 32'd0};
	assign r_shift   = {r_q[POW_W-1:0], sh_q[VAL_W-1]};
	assign r_ge      = r_shift >= {1'b0, p_q};
	assign limit     = {neg_q, {(VAL_W-1){~neg_q}}};
	assign value_out = neg_q ? (VAL_W'(0) - sh_q) : sh_q;

	// character parser and result sequencing
	always_comb begin
		state_d = state_q;
		neg_d   = neg_q;
		mant_d  = mant_q;
		fcnt_d  = fcnt_q;
		ovf_d   = ovf_q;
		if (s_fire) begin
			neg_d   = eff_neg;
			mant_d  = eff_mant;
			fcnt_d  = eff_fcnt;
			ovf_d   = eff_ovf;
			state_d = eff_state;
			unique case (eff_state)
				ST_LEAD: begin
					if (is_ws) begin
						state_d = ST_LEAD;
					end else if (ch == CH_PLUS || ch == CH_MINUS) begin
						neg_d   = (ch == CH_MINUS);
						state_d = ST_INT;
					end else if (is_digit) begin
						mant_d  = (mul10 > INT_CAP) ? INT_CAP : mul10;
						ovf_d   = mul10 > INT_CAP;
						state_d = ST_INT;
					end else if (ch == CH_DOT) begin
						state_d = ST_FRAC;
					end else begin
						state_d = ST_SETUP;
					end
				end
				ST_INT: begin
					if (is_digit) begin
						mant_d = (mul10 > INT_CAP) ? INT_CAP : mul10;
						ovf_d  = eff_ovf | (mul10 > INT_CAP);
					end else if (ch == CH_DOT) begin
						state_d = ST_FRAC;
					end else begin
						state_d = ST_SETUP;
					end
				end
				ST_FRAC: begin
					if (is_digit) begin
						if (eff_fcnt < MAX_FRAC_DIGITS && eff_mant <= FRAC_GUARD) begin
							mant_d = mul10;
							fcnt_d = eff_fcnt + 1'b1;
						end
					end else begin
						state_d = ST_SETUP;
					end
				end
				default: state_d = ST_IDLE;
			endcase
		end else begin
			unique case (state_q)
				ST_SETUP: begin
					if (ovf_q || too_big) begin
						state_d = ST_DONE;
					end else if (fcnt_q == '0) begin
						state_d = ST_CHECK;
					end else begin
						state_d = ST_DIV;
					end
				end
				ST_DIV:   state_d = (cnt_q == CNT_W'(1)) ? ST_CHECK : ST_DIV;
				ST_CHECK: state_d = ST_DONE;
				ST_DONE:  state_d = out_free ? ST_IDLE : ST_DONE;
				default:  state_d = state_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			neg_q   <= 1'b0;
			mant_q  <= '0;
			fcnt_q  <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			neg_q   <= neg_d;
			mant_q  <= mant_d;
			fcnt_q  <= fcnt_d;
			ovf_q   <= ovf_d;
		end
	end

	// restoring divider, one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sat_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_SETUP: begin
					cnt_q <= CNT_W'(VAL_W);
					sat_q <= ovf_q | too_big;
				end
				ST_DIV:   cnt_q <= cnt_q - 1'b1;
				ST_CHECK: sat_q <= sat_q | (sh_q > limit);
				default:  cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_SETUP: begin
				p_q <= pow_sel;
				r_q <= {9'd0, mant_q[MANT_W-1:INT_W]};
				if (ovf_q || too_big) begin
					sh_q <= limit;
				end else begin
					sh_q <= {mant_q[INT_W-1:0], {FRAC_BITS{1'b0}}};
				end
			end
			ST_DIV: begin
				r_q  <= r_ge ? (r_shift - {1'b0, p_q}) : r_shift;
				sh_q <= {sh_q[VAL_W-2:0], r_ge};
			end
			ST_CHECK: begin
				if (sat_q || sh_q > limit) begin
					sh_q <= limit;
				end
			end
			default: sh_q <= sh_q;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			m_tdata_q <= OUT_W'({sat_q, value_out});
		end
	end

`ifndef NO_ASSERTIONS
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> cnt_q != '0)
		else $error("divider running with zero count");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> r_q < {1'b0, p_q})
		else $error("divider remainder not below divisor");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && m_tvalid_q && !m_tready) |=> state_q == ST_DONE)
		else $error("result left while output register busy");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && m_tdata_q[VAL_W]) |->
		(m_tdata_q[VAL_W-1:0] == {1'b0, {(VAL_W-1){1'b1}}}) ||
		(m_tdata_q[VAL_W-1:0] == {1'b1, {(VAL_W-1){1'b0}}}))
		else $error("saturated result not at a range limit");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SETUP || state_q == ST_DIV) |-> !s_tready)
		else $error("request taken while divider busy");
`endif

endmodule
